// ===== rtl/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg: shared types and constants for the positional list engine
// Sizes, opcodes, status codes, item structs and the command that the
// control logic broadcasts to the row of storage cells.
// ----------------------------------------------------------------------------
package ple_pkg;

  // sizing
  localparam int CAPACITY  = 16;
  localparam int WORD_BITS = 32;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int SLOT_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // fixed field widths of the items
  localparam int OP_W   = 3;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 8;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 7;

  // opcodes
  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_POS   = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd4;
  localparam logic [OP_W-1:0] OP_DEL_POS   = 3'd5;
  localparam logic [OP_W-1:0] OP_LIST      = 3'd6;

  // status codes
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

  // cell actions
  localparam logic [1:0] CK_HOLD   = 2'd0;
  localparam logic [1:0] CK_INSERT = 2'd1;
  localparam logic [1:0] CK_DELETE = 2'd2;
  localparam logic [1:0] CK_ROTATE = 2'd3;

  // input item
  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] position;
  } in_t;

  // result item
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  element;
    logic [OCC_W-1:0]  element_index;
    logic [OCC_W-1:0]  occupancy;
    logic              last;
  } out_t;

  // command broadcast to every cell
  typedef struct packed {
    logic [1:0]       kind;
    logic [CNT_W-1:0] slot;
    logic [CNT_W-1:0] count;
  } cell_cmd_t;

endpackage

// ===== rtl/ple_cell.sv =====
// ----------------------------------------------------------------------------
// ple_cell: one storage slot of the list
// Holds one word and, per broadcast command, keeps it, takes the word of
// its left or right neighbor, takes the new word, or takes the head word.
// ----------------------------------------------------------------------------
module ple_cell (
  input  logic                             clk,
  input  ple_pkg::cell_cmd_t               cmd,
  input  logic [ple_pkg::SLOT_W-1:0]       idx,
  input  logic [ple_pkg::WORD_BITS-1:0]    new_word,
  input  logic [ple_pkg::WORD_BITS-1:0]    left,
  input  logic [ple_pkg::WORD_BITS-1:0]    right,
  input  logic [ple_pkg::WORD_BITS-1:0]    head,
  output logic [ple_pkg::WORD_BITS-1:0]    word
);

  logic [ple_pkg::CNT_W-1:0]     pos;
  logic [ple_pkg::CNT_W-1:0]     pos_inc;
  logic [ple_pkg::WORD_BITS-1:0] word_next;

  assign pos     = ple_pkg::CNT_W'(idx);
  assign pos_inc = pos + ple_pkg::CNT_W'(1);

  // pick the source for this slot
  always_comb begin
    word_next = word;
    case (cmd.kind)
      ple_pkg::CK_INSERT: begin
        if (pos == cmd.slot) begin
          word_next = new_word;
        end else if (pos > cmd.slot && pos <= cmd.count) begin
          word_next = left;
        end
      end
      ple_pkg::CK_DELETE: begin
        if (pos >= cmd.slot && pos_inc < cmd.count) begin
          word_next = right;
        end
      end
      ple_pkg::CK_ROTATE: begin
        if (pos_inc < cmd.count) begin
          word_next = right;
        end else if (pos_inc == cmd.count) begin
          word_next = head;
        end
      end
      default: begin
        word_next = word;
      end
    endcase
  end

  // storage
  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

// ===== rtl/positional_list_engine.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine: bounded ordered list with positional edits
// Keeps up to CAPACITY words in a row of cells with an occupancy count.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Every edit (insert
// or delete at front, back or a position) is applied at once: all cells shift
// toward or away from the edit slot in parallel, and the single result
// shows on result for one cycle right after, so a new item may follow in
// the next cycle. A list item on a non-empty list makes the occupied cells
// rotate one step a cycle and sends the head word out each cycle; busy
// stays high meanwhile, and after count steps the list is back in its
// order. A list on an empty list gives one empty marker the next cycle.
// Results cannot be held off, one at most per cycle, marked by result_valid.
// No clearing pass runs after reset.
// ----------------------------------------------------------------------------
module positional_list_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ple_pkg::in_t  command,
  output logic          result_valid,
  output ple_pkg::out_t result
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LIST = 1'b1;

  logic                          state;
  logic                          state_next;
  logic [ple_pkg::CNT_W-1:0]     count;
  logic [ple_pkg::CNT_W-1:0]     count_next;
  logic [ple_pkg::CNT_W-1:0]     step;
  logic [ple_pkg::CNT_W-1:0]     step_inc;
  logic                          accept;
  logic                          full;
  logic                          empty;
  logic [ple_pkg::POS_W:0]       pos_w;
  logic [ple_pkg::POS_W:0]       cnt_w;
  logic [ple_pkg::STAT_W-1:0]    status;
  logic                          edit_result;
  ple_pkg::cell_cmd_t            cmd;
  logic [ple_pkg::WORD_BITS-1:0] new_word;
  logic [ple_pkg::WORD_BITS-1:0] words [ple_pkg::CAPACITY];

  assign busy     = (state == S_LIST);
  assign accept   = start && !busy;
  assign full     = (count == ple_pkg::CNT_W'(ple_pkg::CAPACITY));
  assign empty    = (count == '0);
  assign pos_w    = (ple_pkg::POS_W + 1)'(command.position);
  assign cnt_w    = (ple_pkg::POS_W + 1)'(count);
  assign step_inc = step + ple_pkg::CNT_W'(1);
  assign new_word = ple_pkg::WORD_BITS'(command.value);

  // decode the item into a cell command, new count and status
  always_comb begin
    cmd.kind    = ple_pkg::CK_HOLD;
    cmd.slot    = '0;
    cmd.count   = count;
    count_next  = count;
    status      = ple_pkg::ST_DONE;
    state_next  = state;
    edit_result = 1'b0;
    if (state == S_LIST) begin
      cmd.kind = ple_pkg::CK_ROTATE;
      if (step_inc == count) begin
        state_next = S_IDLE;
      end
    end else if (accept) begin
      edit_result = 1'b1;
      case (command.opcode)
        ple_pkg::OP_INS_FRONT, ple_pkg::OP_INS_BACK: begin
          if (full) begin
            status = ple_pkg::ST_FULL;
          end else begin
            cmd.kind   = ple_pkg::CK_INSERT;
            cmd.slot   = (command.opcode == ple_pkg::OP_INS_FRONT) ? '0 : count;
            count_next = count + ple_pkg::CNT_W'(1);
          end
        end
        ple_pkg::OP_INS_POS: begin
          if (pos_w == '0 || pos_w > cnt_w + (ple_pkg::POS_W + 1)'(1)) begin
            status = ple_pkg::ST_RANGE;
          end else if (full) begin
            status = ple_pkg::ST_FULL;
          end else begin
            cmd.kind   = ple_pkg::CK_INSERT;
            cmd.slot   = ple_pkg::CNT_W'(pos_w - (ple_pkg::POS_W + 1)'(1));
            count_next = count + ple_pkg::CNT_W'(1);
          end
        end
        ple_pkg::OP_DEL_FRONT, ple_pkg::OP_DEL_BACK: begin
          if (empty) begin
            status = ple_pkg::ST_EMPTY;
          end else begin
            cmd.kind   = ple_pkg::CK_DELETE;
            cmd.slot   = (command.opcode == ple_pkg::OP_DEL_FRONT) ? '0 :
                         count - ple_pkg::CNT_W'(1);
            count_next = count - ple_pkg::CNT_W'(1);
          end
        end
        ple_pkg::OP_DEL_POS: begin
          if (empty) begin
            status = ple_pkg::ST_EMPTY;
          end else if (pos_w == '0 || pos_w > cnt_w) begin
            status = ple_pkg::ST_RANGE;
          end else begin
            cmd.kind   = ple_pkg::CK_DELETE;
            cmd.slot   = ple_pkg::CNT_W'(pos_w - (ple_pkg::POS_W + 1)'(1));
            count_next = count - ple_pkg::CNT_W'(1);
          end
        end
        ple_pkg::OP_LIST: begin
          if (empty) begin
            status = ple_pkg::ST_EMPTY;
          end else begin
            edit_result = 1'b0;
            state_next  = S_LIST;
          end
        end
        default: begin
          status = ple_pkg::ST_DONE;
        end
      endcase
    end
  end

  // row of cells, each handing words to its neighbors
  for (genvar i = 0; i < ple_pkg::CAPACITY; i++) begin : g_cell
    logic [ple_pkg::WORD_BITS-1:0] left_word;
    logic [ple_pkg::WORD_BITS-1:0] right_word;
    if (i == 0) begin : g_first
      assign left_word = '0;
    end else begin : g_mid_l
      assign left_word = words[i-1];
    end
    if (i == ple_pkg::CAPACITY - 1) begin : g_end
      assign right_word = '0;
    end else begin : g_mid_r
      assign right_word = words[i+1];
    end
    ple_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .idx      (ple_pkg::SLOT_W'(i)),
      .new_word (new_word),
      .left     (left_word),
      .right    (right_word),
      .head     (words[0]),
      .word     (words[i])
    );
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      step         <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      result_valid <= edit_result || (state == S_LIST);
      if (state == S_LIST) begin
        step <= step_inc;
      end else begin
        step <= '0;
      end
    end
  end

  // result fields
  always_ff @(posedge clk) begin
    if (state == S_LIST) begin
      result.status        <= ple_pkg::ST_DONE;
      result.element       <= ple_pkg::VAL_W'(words[0]);
      result.element_index <= ple_pkg::OCC_W'(step_inc);
      result.occupancy     <= ple_pkg::OCC_W'(count);
      result.last          <= (step_inc == count);
    end else begin
      result.status        <= status;
      result.element       <= '0;
      result.element_index <= '0;
      result.occupancy     <= ple_pkg::OCC_W'(count_next);
      result.last          <= 1'b1;
    end
  end

endmodule

// ===== rtl/ple_checker.sv =====
// ----------------------------------------------------------------------------
// ple_port_checks: port-level checks for the positional list engine
// Watches the item and result ports and flags sequencing slips.
// ----------------------------------------------------------------------------
module ple_port_checks (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input ple_pkg::in_t  command,
  input logic          result_valid,
  input ple_pkg::out_t result
);

  // while listing, a result comes out every cycle
  a_list_stream: assert property (@(posedge clk) disable iff (rst)
    busy |=> result_valid)
    else $error("listing gap: no result while busy");

  // a non-list item gives one final result the next cycle
  a_edit_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command.opcode != ple_pkg::OP_LIST)
      |=> (result_valid && result.last && result.element_index == '0))
    else $error("edit item did not give a single final result");

  // occupancy never exceeds the capacity
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.occupancy <= ple_pkg::OCC_W'(ple_pkg::CAPACITY)))
    else $error("occupancy above capacity");

  // a listed index is within the occupancy, and the final one matches it
  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.element_index != '0)
      |-> (result.element_index <= result.occupancy &&
           (result.last == (result.element_index == result.occupancy))))
    else $error("listed index inconsistent with occupancy");

endmodule

bind positional_list_engine ple_port_checks u_ple_port_checks (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .command      (command),
  .result_valid (result_valid),
  .result       (result)
);

// ===== bench/ple_checker.sv =====
// ----------------------------------------------------------------------------
// ple_checker: result prediction and comparison for the positional list engine
// Watches the command and result channels, keeps its own copy of the list,
// predicts every result of each accepted item and checks them in order.
// ----------------------------------------------------------------------------
module ple_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  ple_pkg::in_t  command,
  input  logic          result_valid,
  input  ple_pkg::out_t result,
  output int            fails,
  output int            pending,
  output int            checked
);

  // shadow copy of the stored words, head first
  logic [ple_pkg::WORD_BITS-1:0] words[$];
  // results still owed by the block, oldest first
  ple_pkg::out_t                 owed_results[$];

  function automatic ple_pkg::out_t make_result(
    input logic [ple_pkg::STAT_W-1:0] st,
    input logic [ple_pkg::VAL_W-1:0]  elem,
    input int                         idx,
    input logic                       fin
  );
    ple_pkg::out_t r;
    r.status        = st;
    r.element       = elem;
    r.element_index = ple_pkg::OCC_W'(idx);
    r.occupancy     = ple_pkg::OCC_W'(words.size());
    r.last          = fin;
    return r;
  endfunction

  // apply one item to the shadow list and queue what it should produce
  task automatic predict_list_op(input ple_pkg::in_t c);
    int                            fill;
    int                            pos;
    logic [ple_pkg::WORD_BITS-1:0] w;
    logic [ple_pkg::STAT_W-1:0]    st;
    fill = words.size();
    pos  = c.position;
    w    = c.value[ple_pkg::WORD_BITS-1:0];
    st   = ple_pkg::ST_DONE;
    case (c.opcode)
      ple_pkg::OP_INS_FRONT, ple_pkg::OP_INS_BACK: begin
        if (fill >= ple_pkg::CAPACITY) st = ple_pkg::ST_FULL;
        else if (c.opcode == ple_pkg::OP_INS_FRONT) words.push_front(w);
        else words.push_back(w);
      end
      ple_pkg::OP_INS_POS: begin
        // position is checked before fullness
        if (pos < 1 || pos > fill + 1) st = ple_pkg::ST_RANGE;
        else if (fill >= ple_pkg::CAPACITY) st = ple_pkg::ST_FULL;
        else words.insert(pos - 1, w);
      end
      ple_pkg::OP_DEL_FRONT, ple_pkg::OP_DEL_BACK: begin
        if (fill == 0) st = ple_pkg::ST_EMPTY;
        else if (c.opcode == ple_pkg::OP_DEL_FRONT) void'(words.pop_front());
        else void'(words.pop_back());
      end
      ple_pkg::OP_DEL_POS: begin
        if (fill == 0) st = ple_pkg::ST_EMPTY;
        else if (pos < 1 || pos > fill) st = ple_pkg::ST_RANGE;
        else words.delete(pos - 1);
      end
      ple_pkg::OP_LIST: begin
        if (fill == 0) st = ple_pkg::ST_EMPTY;
        else begin
          // one result per stored word, last one marked
          for (int i = 0; i < fill; i++)
            owed_results.push_back(make_result(ple_pkg::ST_DONE,
                                               ple_pkg::VAL_W'(words[i]), i + 1,
                                               i + 1 == fill));
          return;
        end
      end
      default: ;
    endcase
    owed_results.push_back(make_result(st, '0, 0, 1'b1));
  endtask

  // compare one result with the oldest one owed
  task automatic check_result(input ple_pkg::out_t got);
    ple_pkg::out_t want;
    bit            bad;
    if (owed_results.size() == 0) begin
      fails++;
      if (fails <= 10)
        $display("[%0t] unexpected result: status %0d element %h index %0d occ %0d last %0b",
                 $realtime, got.status, got.element, got.element_index, got.occupancy,
                 got.last);
      return;
    end
    want = owed_results.pop_front();
    checked++;
    bad = (got.status !== want.status) || (got.element !== want.element) ||
          (got.element_index !== want.element_index) ||
          (got.occupancy !== want.occupancy) || (got.last !== want.last);
    if (bad) begin
      fails++;
      if (fails <= 10) begin
        $display("[%0t] mismatch (expected / actual):", $realtime);
        $display("  status %0d / %0d  element %h / %h  index %0d / %0d",
                 want.status, got.status, want.element, got.element,
                 want.element_index, got.element_index);
        $display("  occupancy %0d / %0d  last %0b / %0b",
                 want.occupancy, got.occupancy, want.last, got.last);
      end
    end
  endtask

  // results first: one seen at this edge belongs to an earlier item
  always @(posedge clk) begin
    if (rst) begin
      words.delete();
      owed_results.delete();
      fails   = 0;
      checked = 0;
    end else begin
      if (result_valid) check_result(result);
      if (start && !busy) predict_list_op(command);
    end
    pending = owed_results.size();
  end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the positional list engine
// Drives directed and random list edits and listings with bursty start
// timing; a checker module beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_top;

  // opcode value that the block treats as no operation
  localparam logic [ple_pkg::OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS = 106;

  typedef enum {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_t;

  logic          clk;
  logic          rst;
  logic          start;
  logic          busy;
  ple_pkg::in_t  command;
  logic          result_valid;
  ple_pkg::out_t result;

  int fails;
  int pending;
  int checked;

  // stimulus bookkeeping: expected fill for shaping, plus run statistics
  int fill;
  int peak_fill;
  int items_sent;
  int lists_sent;
  int full_refusals;
  int burst_left;

  // clock and reset
  initial clk = 1'b0;
  always #1 clk = ~clk;

  positional_list_engine i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .result_valid (result_valid),
    .result       (result)
  );

  ple_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .result_valid (result_valid),
    .result       (result),
    .fails        (fails),
    .pending      (pending),
    .checked      (checked)
  );

  function automatic ple_pkg::in_t list_cmd(input logic [ple_pkg::OP_W-1:0]  op,
                                            input logic [ple_pkg::VAL_W-1:0] val,
                                            input logic [ple_pkg::POS_W-1:0] pos);
    ple_pkg::in_t c;
    c.opcode   = op;
    c.value    = val;
    c.position = pos;
    return c;
  endfunction

  // present one item, hold it until taken, then maybe idle for a while
  task automatic send_item(input ple_pkg::in_t c);
    int pos;
    start   <= 1'b1;
    command <= c;
    do @(posedge clk); while (busy);
    pos = c.position;
    items_sent++;
    case (c.opcode)
      ple_pkg::OP_INS_FRONT, ple_pkg::OP_INS_BACK: begin
        if (fill < ple_pkg::CAPACITY) fill++;
        else full_refusals++;
      end
      ple_pkg::OP_INS_POS: begin
        if (pos >= 1 && pos <= fill + 1) begin
          if (fill < ple_pkg::CAPACITY) fill++;
          else full_refusals++;
        end
      end
      ple_pkg::OP_DEL_FRONT, ple_pkg::OP_DEL_BACK: if (fill > 0) fill--;
      ple_pkg::OP_DEL_POS: if (fill > 0 && pos >= 1 && pos <= fill) fill--;
      ple_pkg::OP_LIST: lists_sent++;
      default: ;
    endcase
    if (fill > peak_fill) peak_fill = fill;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start   <= 1'b0;
      command <= list_cmd(ple_pkg::OP_W'($urandom), $urandom,
                          ple_pkg::POS_W'($urandom));
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(0, 8);
    end
  endtask

  // stop sending until every owed result has come back
  task automatic drain;
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // stimulus and verdict
  initial begin
    mix_t                        mix;
    int                          r;
    int                          ins_pct;
    int                          lim;
    logic [ple_pkg::OP_W-1:0]    op;
    logic [ple_pkg::VAL_W-1:0]   val;
    logic [ple_pkg::POS_W-1:0]   pos;

    rst           = 1'b1;
    start         = 1'b0;
    command       = '0;
    fill          = 0;
    peak_fill     = 0;
    items_sent    = 0;
    lists_sent    = 0;
    full_refusals = 0;
    burst_left    = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty-list cases, edge positions, extreme words
    send_item(list_cmd(ple_pkg::OP_LIST,      '0,           8'd0));
    send_item(list_cmd(ple_pkg::OP_DEL_FRONT, '0,           8'd0));
    send_item(list_cmd(ple_pkg::OP_DEL_BACK,  '0,           8'd0));
    send_item(list_cmd(ple_pkg::OP_DEL_POS,   '0,           8'd1));
    send_item(list_cmd(ple_pkg::OP_INS_POS,   32'h1111_1111, 8'd0));
    send_item(list_cmd(ple_pkg::OP_INS_POS,   '1,           8'd255));
    send_item(list_cmd(ple_pkg::OP_INS_POS,   '0,           8'd1));
    send_item(list_cmd(ple_pkg::OP_INS_FRONT, '1,           8'd0));
    send_item(list_cmd(ple_pkg::OP_INS_BACK,  32'hA5A5_A5A5, 8'd255));
    send_item(list_cmd(ple_pkg::OP_INS_POS,   32'h5A5A_5A5A, 8'd4));
    send_item(list_cmd(ple_pkg::OP_INS_POS,   32'h1234_5678, 8'd2));
    send_item(list_cmd(ple_pkg::OP_LIST,      '1,           8'd255));
    send_item(list_cmd(ple_pkg::OP_DEL_POS,   '0,           8'd0));
    send_item(list_cmd(ple_pkg::OP_DEL_POS,   '0,           8'd255));
    send_item(list_cmd(ple_pkg::OP_DEL_POS,   '0,           8'd6));
    send_item(list_cmd(ple_pkg::OP_DEL_POS,   '0,           8'd3));
    send_item(list_cmd(ple_pkg::OP_DEL_FRONT, '1,           8'd0));
    send_item(list_cmd(ple_pkg::OP_DEL_BACK,  '0,           8'd0));
    send_item(list_cmd(OP_UNUSED,             '1,           8'd255));
    send_item(list_cmd(ple_pkg::OP_LIST,      '0,           8'd0));
    send_item(list_cmd(ple_pkg::OP_DEL_POS,   '0,           8'd1));
    // removing the only word leaves a clean empty list
    send_item(list_cmd(ple_pkg::OP_DEL_POS,   '0,           8'd1));
    send_item(list_cmd(ple_pkg::OP_LIST,      '0,           8'd0));
    send_item(list_cmd(ple_pkg::OP_INS_BACK,  32'h0000_0001, 8'd0));
    drain();

    // random: phases that fill up, drain down and mix
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      mix = mix_t'((k / 25) % 3);
      case (mix)
        MIX_GROW:   ins_pct = 80;
        MIX_SHRINK: ins_pct = 15;
        default:    ins_pct = 45;
      endcase
      r = $urandom_range(0, 99);
      if (r < ins_pct) begin
        case ($urandom_range(0, 2))
          0:       op = ple_pkg::OP_INS_FRONT;
          1:       op = ple_pkg::OP_INS_BACK;
          default: op = ple_pkg::OP_INS_POS;
        endcase
      end else if (r < ins_pct + 8) begin
        op = ple_pkg::OP_LIST;
      end else if (r < ins_pct + 10) begin
        op = OP_UNUSED;
      end else begin
        case ($urandom_range(0, 2))
          0:       op = ple_pkg::OP_DEL_FRONT;
          1:       op = ple_pkg::OP_DEL_BACK;
          default: op = ple_pkg::OP_DEL_POS;
        endcase
      end

      case ($urandom_range(0, 9))
        0:       val = '0;
        1:       val = '1;
        default: val = $urandom;
      endcase

      // positions mostly in range, some just outside or far off
      if (op == ple_pkg::OP_INS_POS || op == ple_pkg::OP_DEL_POS) begin
        lim = (op == ple_pkg::OP_INS_POS) ? fill + 1 : fill;
        if (lim > 0 && $urandom_range(0, 99) < 85)
          pos = ple_pkg::POS_W'($urandom_range(1, lim));
        else if ($urandom_range(0, 3) == 0) pos = '0;
        else pos = ple_pkg::POS_W'($urandom_range(lim + 1, 255));
      end else begin
        pos = ple_pkg::POS_W'($urandom_range(0, 255));
      end

      send_item(list_cmd(op, val, pos));
      if (k == RANDOM_ITEMS / 2) drain();
    end

    // wait out every owed result, then idle quietly before the verdict
    drain();
    repeat (8) @(posedge clk);

    $display("run covered %0d items (%0d listings), %0d results checked",
             items_sent, lists_sent, checked);
    $display("fill peaked at %0d of %0d, %0d inserts refused on a full list",
             peak_fill, ple_pkg::CAPACITY, full_refusals);
    if (pending != 0)
      $display("%0d expected results never arrived", pending);
    if (fails == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", fails);
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("timeout with %0d results still expected", pending);
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== positional_list_engine.f =====
rtl/ple_pkg.sv
rtl/ple_cell.sv
rtl/positional_list_engine.sv
rtl/ple_checker.sv
bench/ple_checker.sv
bench/tb_top.sv
